/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, ck, rn, prop)
`define ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

/* rtl/core/xlb_pkg.sv */
// ----------------------------------------------------------------------------
// xlb_pkg
// Request, response and pass-control types of the XOR linear basis.
// ----------------------------------------------------------------------------
`default_nettype none

package xlb_pkg;

  localparam int FIELD_BITS = 61;
  localparam int RANK_BITS  = 6;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [FIELD_BITS-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] max_xor;
    logic [RANK_BITS-1:0]  rank;
    logic                  added;
  } out_rsp_t;

  typedef struct packed {
    logic valid;
    logic is_query;
    logic found;
  } pass_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/xor_linear_basis.sv */
// ----------------------------------------------------------------------------
// xor_linear_basis
// Fully reduced GF(2) XOR basis with rank; clear, insert and max-xor query.
// ----------------------------------------------------------------------------
// Usage: a request (opcode, value) is taken on in_valid with in_stall low;
// in_stall is high while a request is being worked on. Each request gives
// exactly one response on out_valid/out_stall, in order.
// Insert and query send the word through the chain of WORD_BITS row cells,
// one cell per cycle. An insert that survives writes its new row and clears
// its leading bit from the other rows in the cycle the pass ends. Clear and
// the unused opcode go straight to the response without the chain.
// A finished response waits in the output register while out_stall is
// high; the next request is taken as soon as that register is loaded, and
// a second finished response waits inside until the register frees.
// Reset empties the basis, zeroes the rank and drops any response.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module xor_linear_basis #(
  parameter int WORD_BITS = 61
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire xlb_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xlb_pkg::out_rsp_t      out_data
);

  localparam int RankW = $clog2(WORD_BITS + 1);
  localparam int FB    = xlb_pkg::FIELD_BITS;
  localparam int RB    = xlb_pkg::RANK_BITS;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [RankW-1:0]     rank_r, rank_nxt;
  xlb_pkg::pass_ctl_t   launch_ctl_r, launch_ctl_nxt;
  logic [WORD_BITS-1:0] launch_acc_r, launch_acc_nxt;
  logic [FB-1:0]        max_r, max_nxt;
  logic                 added_r, added_nxt;
  logic                 out_valid_r, out_valid_nxt;
  xlb_pkg::out_rsp_t    out_data_r, out_data_nxt;
  logic                 clr;
  logic                 wb_en;
  xlb_pkg::pass_ctl_t   done_ctl;
  logic [WORD_BITS-1:0] done_acc;
  logic [FB+WORD_BITS-1:0] value_ext;
  logic [FB+WORD_BITS-1:0] max_ext;
  logic [RankW+RB-1:0]     rank_ext;

  assign value_ext = {{WORD_BITS{1'b0}}, in_data.value};
  assign max_ext   = {{FB{1'b0}}, done_acc};
  assign rank_ext  = {{RB{1'b0}}, rank_r};
  assign in_stall  = (state_r != S_IDLE);

  xlb_chain #(
    .WORD_BITS (WORD_BITS)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .launch_ctl (launch_ctl_r),
    .launch_acc (launch_acc_r),
    .wb_en      (wb_en),
    .done_ctl   (done_ctl),
    .done_acc   (done_acc)
  );

  always_comb begin
    state_nxt      = state_r;
    rank_nxt       = rank_r;
    launch_ctl_nxt = '0;
    launch_acc_nxt = launch_acc_r;
    max_nxt        = max_r;
    added_nxt      = added_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    clr            = 1'b0;
    wb_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          max_nxt   = '0;
          added_nxt = 1'b0;
          state_nxt = S_DONE;
          unique case (in_data.opcode)
            xlb_pkg::OP_CLEAR: begin
              clr      = 1'b1;
              rank_nxt = '0;
            end
            xlb_pkg::OP_INSERT, xlb_pkg::OP_QUERY: begin
              launch_ctl_nxt.valid    = 1'b1;
              launch_ctl_nxt.is_query = (in_data.opcode == xlb_pkg::OP_QUERY);
              launch_ctl_nxt.found    = 1'b0;
              launch_acc_nxt          = value_ext[WORD_BITS-1:0];
              state_nxt               = S_RUN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RUN: begin
        if (done_ctl.valid) begin
          max_nxt   = done_ctl.is_query ? max_ext[FB-1:0] : '0;
          added_nxt = !done_ctl.is_query && done_ctl.found;
          wb_en     = added_nxt;
          if (added_nxt) begin
            rank_nxt = rank_r + RankW'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.max_xor = max_r;
          out_data_nxt.rank    = rank_ext[RB-1:0];
          out_data_nxt.added   = added_r;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rank_r       <= '0;
      launch_ctl_r <= '0;
      launch_acc_r <= '0;
      max_r        <= '0;
      added_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      rank_r       <= rank_nxt;
      launch_ctl_r <= launch_ctl_nxt;
      launch_acc_r <= launch_acc_nxt;
      max_r        <= max_nxt;
      added_r      <= added_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_done_outside_run, clk, rst_n, done_ctl.valid && (state_r != S_RUN))
  `ASSERT_PROP(a_rank_step, clk, rst_n, wb_en |=> (rank_r == RankW'($past(rank_r) + 1'b1)))
  `ASSERT_PROP(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE))

endmodule

`default_nettype wire

/* rtl/core/xlb_cell.sv */
// ----------------------------------------------------------------------------
// xlb_cell
// One basis row: reduces an insert word or raises a query word by its row,
// marks the leading bit of a surviving insert, applies the new vector's update.
// ----------------------------------------------------------------------------
`default_nettype none

module xlb_cell #(
  parameter int WORD_BITS = 61,
  parameter int IDX       = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clr,
  input  wire xlb_pkg::pass_ctl_t     ctl_in,
  input  wire logic [WORD_BITS-1:0]   acc_in,
  output xlb_pkg::pass_ctl_t          ctl_out,
  output logic      [WORD_BITS-1:0]   acc_out,
  output logic                        lead,
  input  wire logic                   wb_en,
  input  wire logic [WORD_BITS-1:0]   wb_word,
  input  wire logic [WORD_BITS-1:0]   lead_vec
);

  logic [WORD_BITS-1:0] row_r, row_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  xlb_pkg::pass_ctl_t   ctl_r, ctl_nxt;
  logic                 lead_r, lead_nxt;
  logic                 hit;
  logic                 lead_now;

  always_comb begin
    hit      = (|row_r) && (acc_in[IDX] != ctl_in.is_query);
    acc_nxt  = hit ? (acc_in ^ row_r) : acc_in;
    lead_now = !ctl_in.is_query && !ctl_in.found && acc_nxt[IDX];
    ctl_nxt       = ctl_in;
    ctl_nxt.found = ctl_in.found | lead_now;
    lead_nxt = ctl_in.valid ? lead_now : lead_r;
    priority if (clr) begin
      row_nxt = '0;
    end else if (wb_en && lead_r) begin
      row_nxt = wb_word;
    end else if (wb_en && (|(row_r & lead_vec))) begin
      row_nxt = row_r ^ wb_word;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      ctl_r  <= '0;
      lead_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      ctl_r  <= ctl_nxt;
      lead_r <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign acc_out = acc_r;
  assign lead    = lead_r;

endmodule

`default_nettype wire

/* rtl/core/xlb_chain.sv */
// ----------------------------------------------------------------------------
// xlb_chain
// Row of basis cells, top row first; the word steps one cell per cycle and
// the surviving insert word is broadcast to all cells in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xlb_chain #(
  parameter int WORD_BITS = 61
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire xlb_pkg::pass_ctl_t   launch_ctl,
  input  wire logic [WORD_BITS-1:0] launch_acc,
  input  wire logic                 wb_en,
  output xlb_pkg::pass_ctl_t        done_ctl,
  output logic      [WORD_BITS-1:0] done_acc
);

  xlb_pkg::pass_ctl_t   ctl_link [WORD_BITS:0];
  logic [WORD_BITS-1:0] acc_link [WORD_BITS:0];
  logic [WORD_BITS-1:0] lead_vec;

  assign ctl_link[WORD_BITS] = launch_ctl;
  assign acc_link[WORD_BITS] = launch_acc;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
    xlb_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (clr),
      .ctl_in   (ctl_link[i+1]),
      .acc_in   (acc_link[i+1]),
      .ctl_out  (ctl_link[i]),
      .acc_out  (acc_link[i]),
      .lead     (lead_vec[i]),
      .wb_en    (wb_en),
      .wb_word  (acc_link[0]),
      .lead_vec (lead_vec)
    );
  end

  assign done_ctl = ctl_link[0];
  assign done_acc = acc_link[0];

endmodule

`default_nettype wire
